// File: src/bit_vector_majority_downsampler_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bit vector majority downsampler
// Overlapping (same-cycle) and next-cycle concurrent implication checks on the clock domain.
// ----------------------------------------------------------------------------
`ifndef BIT_VECTOR_MAJORITY_DOWNSAMPLER_TOP_ASSERT_SVH
`define BIT_VECTOR_MAJORITY_DOWNSAMPLER_TOP_ASSERT_SVH

// same-cycle implication
`define BVMD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// next-cycle implication
`define BVMD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// File: src/bvmd_pkg.sv
// ----------------------------------------------------------------------------
// bvmd_pkg
// Widths, register indexes and defaults of the majority downsampler.
// ----------------------------------------------------------------------------
package bvmd_pkg;

   localparam int CFG_W            = 17;
   localparam int IDX_W            = 16;
   localparam int CSR_IDX_W        = 1;
   localparam int MAX_BITS_DEFAULT = 65536;

   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_OUTPUTS   = 1'b1;

endpackage

// File: src/bit_vector_majority_downsampler_top.sv
// ----------------------------------------------------------------------------
// bit_vector_majority_downsampler_top
// Squeezes a source bit vector of N bits into at most M output bits.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : register writes (index 0 source length N, index 1 max outputs M),
//            taken while csr_ready is high; any write restarts the vector.
//   req_*  : one source bit per beat, in index order; req_stall holds off
//            the sender while a bit is being worked on or a write is offered.
//   rsp_*  : zero or one output beat per source bit, held in an output
//            register until the receiver drops rsp_stall.
// Processing:
//   A source bit is accepted, then the group counters are updated.
//   The first bit of a vector with N > M also runs a restoring division by M
//   on the shared divider, and a second one by M-1 when N mod M is nonzero.
//   A bit can be accepted while the previous result still waits in the
//   output register; the counter update waits only if it must emit a beat
//   and the register is still occupied.
// Reset clears the control registers and progress: N = 0 (all bits dropped), M = 1.
// ----------------------------------------------------------------------------
module bit_vector_majority_downsampler_top
   #(parameter int MAX_BITS = bvmd_pkg::MAX_BITS_DEFAULT)
   (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_src_bit,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_out_bit,
   output logic [bvmd_pkg::IDX_W-1:0]      rsp_out_index,
   output logic                            rsp_out_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bvmd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bvmd_pkg::CFG_W-1:0]      csr_wdata
   );

   import bvmd_pkg::*;

`include "bit_vector_majority_downsampler_top_assert.svh"

   localparam int CNT_W = $clog2(CFG_W);
   localparam logic [CFG_W-1:0] LEN_CAP =
      (MAX_BITS > 131071) ? {CFG_W{1'b1}} : CFG_W'(MAX_BITS);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_PROC} state_type;

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   source_length_ff, source_length_in;
   logic [CFG_W-1:0]   max_outputs_ff, max_outputs_in;
   logic [CFG_W-1:0]   source_position_ff, source_position_in;
   logic [CFG_W-1:0]   group_fill_ff, group_fill_in;
   logic [CFG_W-1:0]   ones_in_group_ff, ones_in_group_in;
   logic [CFG_W-1:0]   outputs_done_ff, outputs_done_in;
   logic [CFG_W-1:0]   group_size_ff, group_size_in;
   logic [CFG_W-1:0]   output_total_ff, output_total_in;
   logic               bit_ff, bit_in;
   logic [CFG_W-1:0]   quo_ff, quo_in;
   logic [CFG_W-1:0]   rem_ff, rem_in;
   logic [CFG_W-1:0]   divisor_ff, divisor_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               second_ff, second_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_bit_ff, rsp_bit_in;
   logic [IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [CFG_W-1:0]   eff_len;
   logic [CFG_W-1:0]   eff_max;
   logic               pass_mode;
   logic [CFG_W:0]     pos_next;
   logic               src_last;
   logic [CFG_W-1:0]   fill_next;
   logic [CFG_W-1:0]   ones_next;
   logic               close;
   logic               emit;
   logic               out_free;
   logic [CFG_W:0]     partial;
   logic [CFG_W:0]     diff;
   logic               ge;
   logic [CFG_W-1:0]   quo_step;
   logic [CFG_W-1:0]   rem_step;

   assign eff_len   = (source_length_ff > LEN_CAP) ? LEN_CAP : source_length_ff;
   assign eff_max   = (max_outputs_ff == '0) ? CFG_W'(1) : max_outputs_ff;
   assign pass_mode = (eff_len <= eff_max);
   assign pos_next  = {1'b0, source_position_ff} + (CFG_W+1)'(1);
   assign src_last  = (pos_next >= {1'b0, eff_len});
   assign fill_next = group_fill_ff + CFG_W'(1);
   assign ones_next = ones_in_group_ff + CFG_W'(bit_ff);
   assign close     = (fill_next >= group_size_ff) || src_last;
   assign emit      = (eff_len != '0) &&
                      (pass_mode || (close && (outputs_done_ff < output_total_ff)));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign partial  = {rem_ff, quo_ff[CFG_W-1]};
   assign diff     = partial - {1'b0, divisor_ff};
   assign ge       = (partial >= {1'b0, divisor_ff});
   assign quo_step = {quo_ff[CFG_W-2:0], ge};
   assign rem_step = ge ? diff[CFG_W-1:0] : partial[CFG_W-1:0];

   assign req_stall     = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_bit   = rsp_bit_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_last  = rsp_last_ff;

   always_comb begin
      state_in           = state_ff;
      source_length_in   = source_length_ff;
      max_outputs_in     = max_outputs_ff;
      source_position_in = source_position_ff;
      group_fill_in      = group_fill_ff;
      ones_in_group_in   = ones_in_group_ff;
      outputs_done_in    = outputs_done_ff;
      group_size_in      = group_size_ff;
      output_total_in    = output_total_ff;
      bit_in             = bit_ff;
      quo_in             = quo_ff;
      rem_in             = rem_ff;
      divisor_in         = divisor_ff;
      count_in           = count_ff;
      second_in          = second_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_bit_in         = rsp_bit_ff;
      rsp_index_in       = rsp_index_ff;
      rsp_last_in        = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               unique case (csr_index)
                  REG_SOURCE_LENGTH: source_length_in = csr_wdata;
                  REG_MAX_OUTPUTS:   max_outputs_in   = csr_wdata;
               endcase
               source_position_in = '0;
               group_fill_in      = '0;
               ones_in_group_in   = '0;
               outputs_done_in    = '0;
               group_size_in      = '0;
               output_total_in    = '0;
            end else if (req_valid) begin
               bit_in = req_src_bit;
               if ((eff_len != '0) && !pass_mode && (source_position_ff == '0)) begin
                  quo_in     = eff_len;
                  rem_in     = '0;
                  divisor_in = eff_max;
                  count_in   = CNT_W'(CFG_W-1);
                  second_in  = 1'b0;
                  state_in   = ST_DIV;
               end else begin
                  state_in = ST_PROC;
               end
            end
         end
         ST_DIV: begin
            quo_in   = quo_step;
            rem_in   = rem_step;
            count_in = count_ff - CNT_W'(1);
            if (count_ff == '0) begin
               if (!second_ff && (rem_step != '0)) begin
                  quo_in     = eff_len;
                  rem_in     = '0;
                  divisor_in = eff_max - CFG_W'(1);
                  count_in   = CNT_W'(CFG_W-1);
                  second_in  = 1'b1;
               end else begin
                  group_size_in    = quo_step;
                  output_total_in  = (second_ff && (rem_step == '0)) ?
                                     eff_max - CFG_W'(1) : eff_max;
                  group_fill_in    = '0;
                  ones_in_group_in = '0;
                  outputs_done_in  = '0;
                  state_in         = ST_PROC;
               end
            end
         end
         ST_PROC: begin
            if (!emit || out_free) begin
               state_in = ST_IDLE;
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  if (pass_mode) begin
                     rsp_bit_in   = bit_ff;
                     rsp_index_in = source_position_ff[IDX_W-1:0];
                     rsp_last_in  = src_last;
                  end else begin
                     rsp_bit_in   = (ones_next >= (fill_next >> 1));
                     rsp_index_in = outputs_done_ff[IDX_W-1:0];
                     rsp_last_in  = ((outputs_done_ff + CFG_W'(1)) == output_total_ff);
                  end
               end
               if (eff_len != '0) begin
                  if (!pass_mode) begin
                     if (close) begin
                        group_fill_in    = '0;
                        ones_in_group_in = '0;
                        if (outputs_done_ff < output_total_ff) begin
                           outputs_done_in = outputs_done_ff + CFG_W'(1);
                        end
                     end else begin
                        group_fill_in    = fill_next;
                        ones_in_group_in = ones_next;
                     end
                  end
                  if (src_last) begin
                     source_position_in = '0;
                     group_fill_in      = '0;
                     ones_in_group_in   = '0;
                     outputs_done_in    = '0;
                     group_size_in      = '0;
                     output_total_in    = '0;
                  end else begin
                     source_position_in = pos_next[CFG_W-1:0];
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         source_length_ff   <= '0;
         max_outputs_ff     <= CFG_W'(1);
         source_position_ff <= '0;
         group_fill_ff      <= '0;
         ones_in_group_ff   <= '0;
         outputs_done_ff    <= '0;
         group_size_ff      <= '0;
         output_total_ff    <= '0;
         count_ff           <= '0;
         second_ff          <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         source_length_ff   <= source_length_in;
         max_outputs_ff     <= max_outputs_in;
         source_position_ff <= source_position_in;
         group_fill_ff      <= group_fill_in;
         ones_in_group_ff   <= ones_in_group_in;
         outputs_done_ff    <= outputs_done_in;
         group_size_ff      <= group_size_in;
         output_total_ff    <= output_total_in;
         count_ff           <= count_in;
         second_ff          <= second_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      bit_ff       <= bit_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      rsp_bit_ff   <= rsp_bit_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   `BVMD_ASSERT_IMP(div_nonzero_divisor, clock, reset,
      state_ff == ST_DIV, divisor_ff != '0)
   `BVMD_ASSERT_IMP(group_fill_in_range, clock, reset,
      (state_ff == ST_PROC) && (eff_len != '0) && !pass_mode,
      (group_fill_ff < group_size_ff) && (outputs_done_ff <= output_total_ff))
   `BVMD_ASSERT_NXT(csr_write_restarts, clock, reset,
      csr_valid && csr_ready, (source_position_ff == '0) && (outputs_done_ff == '0))
   `BVMD_ASSERT_NXT(blocked_emit_holds, clock, reset,
      (state_ff == ST_PROC) && emit && !out_free,
      (state_ff == ST_PROC) && $stable(source_position_ff))

endmodule

// File: tb/bvmd_majority_checker.sv
// ----------------------------------------------------------------------------
// bvmd_majority_checker
// Watches the register, source and output channels of the majority
// downsampler. It keeps its own copy of the registers and the group counters,
// predicts the output beat, if any, of every accepted source bit, and compares each
// accepted output beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bvmd_majority_checker
   #(parameter int MAX_BITS = bvmd_pkg::MAX_BITS_DEFAULT)
   (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_src_bit,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_out_bit,
   input  logic [bvmd_pkg::IDX_W-1:0]      rsp_out_index,
   input  logic                            rsp_out_last,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [bvmd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bvmd_pkg::CFG_W-1:0]      csr_wdata,
   output int                              mismatch_count,
   output int                              awaited_count
   );

   import bvmd_pkg::*;

   typedef struct packed {
      logic             value;
      logic [IDX_W-1:0] index;
      logic             last;
   } out_beat_type;

   logic [CFG_W-1:0] src_len;
   logic [CFG_W-1:0] max_outs;

   int unsigned src_pos;
   int unsigned grp_fill;
   int unsigned grp_ones;
   int unsigned outs_done;
   int unsigned grp_size;
   int unsigned out_total;

   out_beat_type awaited_beats[$];
   int           errors = 0;

   function automatic void restart_vector();
      src_pos   = 0;
      grp_fill  = 0;
      grp_ones  = 0;
      outs_done = 0;
      grp_size  = 0;
      out_total = 0;
   endfunction

   function automatic void take_source_bit(input logic b);
      int unsigned  n;
      int unsigned  m;
      logic         at_end;
      out_beat_type beat;
      n = (src_len > MAX_BITS) ? MAX_BITS : src_len;
      m = (max_outs == 0) ? 1 : max_outs;
      if (n == 0)
         return;
      at_end = (src_pos + 1 >= n);
      if (n <= m) begin
         beat.value = b;
         beat.index = src_pos[IDX_W-1:0];
         beat.last  = at_end;
         awaited_beats.push_back(beat);
      end else begin
         if (src_pos == 0) begin
            if (n % m != 0) begin
               grp_size  = n / (m - 1);
               out_total = (n % (m - 1) == 0) ? m - 1 : m;
            end else begin
               grp_size  = n / m;
               out_total = m;
            end
            grp_fill  = 0;
            grp_ones  = 0;
            outs_done = 0;
         end
         grp_fill++;
         grp_ones += b;
         if (grp_fill >= grp_size || at_end) begin
            if (outs_done < out_total) begin
               beat.value = (grp_ones >= grp_fill / 2);
               beat.index = outs_done[IDX_W-1:0];
               beat.last  = (outs_done + 1 == out_total);
               awaited_beats.push_back(beat);
               outs_done++;
            end
            grp_fill = 0;
            grp_ones = 0;
         end
      end
      if (at_end)
         restart_vector();
      else
         src_pos = src_pos + 1;
   endfunction

   function automatic void check_out_beat();
      out_beat_type want;
      if (awaited_beats.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected output beat: bit=%0d index=%0d last=%0d",
                     rsp_out_bit, rsp_out_index, rsp_out_last);
      end else begin
         want = awaited_beats.pop_front();
         if (want.value !== rsp_out_bit || want.index !== rsp_out_index ||
             want.last !== rsp_out_last) begin
            errors++;
            if (errors <= 10)
               $display("beat mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                        want.value, want.index, want.last,
                        rsp_out_bit, rsp_out_index, rsp_out_last);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         src_len  = '0;
         max_outs = 1;
         restart_vector();
         awaited_beats.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SOURCE_LENGTH: src_len  = csr_wdata;
               REG_MAX_OUTPUTS:   max_outs = csr_wdata;
            endcase
            restart_vector();
         end
         if (rsp_valid && !rsp_stall)
            check_out_beat();
         if (req_valid && !req_stall)
            take_source_bit(req_src_bit);
      end
      mismatch_count <= errors;
      awaited_count  <= awaited_beats.size();
   end

endmodule

// File: tb/bit_vector_majority_downsampler_top_tb.sv
// ----------------------------------------------------------------------------
// bit_vector_majority_downsampler_top_tb
// Drives register writes and source bits into the majority downsampler and
// gives the verdict. A directed part covers the register extremes, the
// pass-through, reduced-count, leftover and early-close cases; random vectors
// follow under several idle and stall mixes and one long receiver hold-off.
// Prediction and comparison live in bvmd_majority_checker.
// ----------------------------------------------------------------------------
module bit_vector_majority_downsampler_top_tb;

   import bvmd_pkg::*;

   localparam int SETTLE_CYCLES  = 64;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 150;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_src_bit;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_out_bit;
   logic [IDX_W-1:0]     rsp_out_index;
   logic                 rsp_out_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   int mismatches;
   int awaited;
   int send_idle_pct;
   int stall_pct;
   int hold_asked;
   int hold_given;
   int quiet_cycles = 0;

   always #4 clock = ~clock;

   bit_vector_majority_downsampler_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_src_bit   (req_src_bit),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_bit   (rsp_out_bit),
      .rsp_out_index (rsp_out_index),
      .rsp_out_last  (rsp_out_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   bvmd_majority_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_src_bit    (req_src_bit),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_bit    (rsp_out_bit),
      .rsp_out_index  (rsp_out_index),
      .rsp_out_last   (rsp_out_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatches),
      .awaited_count  (awaited)
   );

   initial begin
      rsp_stall  = 1'b0;
      hold_given = 0;
      forever begin
         @(posedge clock);
         if (hold_given != hold_asked) begin
            hold_given++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic send_bit(input logic b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_src_bit <= b;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_pattern(input logic [15:0] bits, input int count);
      for (int i = 0; i < count; i++)
         send_bit(bits[i]);
   endtask

   task automatic send_random(input int count, input int density);
      for (int i = 0; i < count; i++)
         send_bit($urandom_range(99) < density);
   endtask

   // drain: drop valid, wait out predicted beats and any silent division
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] mx);
      logic len_first;
      len_first = 1'($urandom_range(1));
      csr_valid <= 1'b1;
      csr_index <= len_first ? REG_SOURCE_LENGTH : REG_MAX_OUTPUTS;
      csr_wdata <= len_first ? len : mx;
      do @(posedge clock); while (!csr_ready);
      csr_index <= len_first ? REG_MAX_OUTPUTS : REG_SOURCE_LENGTH;
      csr_wdata <= len_first ? mx : len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_sets(input int target);
      int               sent;
      int               pick;
      int               dens;
      int               reps;
      logic [CFG_W-1:0] len;
      logic [CFG_W-1:0] mx;
      sent = 0;
      while (sent < target) begin
         pick = $urandom_range(99);
         dens = $urandom_range(100);
         if (pick < 5) begin
            len = '0;
            mx  = CFG_W'($urandom_range(8));
         end else if (pick < 15) begin
            len = CFG_W'($urandom_range(17'h1FFFF));
            mx  = CFG_W'($urandom_range(17'h1FFFF));
         end else begin
            len = CFG_W'($urandom_range(1, 48));
            mx  = CFG_W'($urandom_range(0, len + 4));
         end
         settle();
         write_regs(len, mx);
         if (pick < 15) begin
            reps = $urandom_range(1, 6);
            send_random(reps, dens);
            if (len != 0)
               sent += reps;
         end else if (pick < 30) begin
            reps = $urandom_range(1, len);
            send_random(reps, dens);
            sent += reps;
         end else begin
            reps = $urandom_range(1, 3);
            send_random(reps * len, dens);
            sent += reps * len;
         end
      end
   endtask

   initial begin
      int idle_mix[4];
      int stall_mix[4];
      idle_mix      = '{0, 58, 0, 23};
      stall_mix     = '{0, 0, 58, 23};
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_src_bit   = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = REG_SOURCE_LENGTH;
      csr_wdata     = '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_asked    = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_pattern(16'b10, 2);
      settle();
      write_regs(3, 0);
      send_pattern(16'b001, 3);
      settle();
      write_regs(17'h1FFFF, 17'h1FFFF);
      send_pattern(16'b01, 2);
      settle();
      write_regs(17'h10000, 1);
      send_pattern(16'b1, 1);
      settle();
      write_regs(7, 3);
      send_pattern(16'b0011000, 7);
      settle();
      write_regs(6, 4);
      send_pattern(16'b110100, 6);
      settle();
      write_regs(5, 4);
      send_pattern(16'b10010, 5);

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_mix[p];
         stall_pct     = stall_mix[p];
         run_random_sets(PHASE_ITEMS);
      end

      // fill the block while the receiver holds off
      send_idle_pct = 0;
      stall_pct     = 0;
      settle();
      write_regs(64, 64);
      hold_asked++;
      send_random(64, 50);

      settle();
      if (mismatches == 0 && awaited == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
